/* rtl/bbc_pkg.sv */
// Package for the block buffer cache controller: status codes, widths,
// the request struct shared by front end, queue and back end, and state enums.
`timescale 1ns / 1ps
`default_nettype none
package bbc_pkg;
    localparam int SECTOR_W = 48;
    localparam int SPB_W    = 9;
    localparam int STAMP_W  = 64;
    localparam int IDX_W    = 5;
    localparam int BUFFERS_DEFAULT = 8;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_RANGE    = 3'd2,
        ST_FLUSH_WB = 3'd3,
        ST_FLUSH_DN = 3'd4
    } t_status;

    localparam logic CFG_SPB = 1'b0;
    localparam logic CFG_VOL = 1'b1;

    typedef enum logic [1:0] {
        K_ACCESS = 2'd0,
        K_FLUSH  = 2'd1,
        K_RANGE  = 2'd2
    } t_kind;

    // classified request handed from front end to back end
    typedef struct packed {
        t_kind                kind;
        logic                 write;
        logic [SECTOR_W-1:0]  sector;
        logic [SECTOR_W-1:0]  fill;
    } t_req;

    typedef enum logic [2:0] {
        B_IDLE, B_SCAN, B_PICK, B_EMIT, B_FLUSH, B_DONE
    } t_bstate;

    typedef enum logic [1:0] {
        F_IDLE, F_DIV, F_PUSH
    } t_fstate;
endpackage
`default_nettype wire

/* rtl/bbc_front.sv */
// Front end: accepts requests, checks range, computes the aligned fill
// sector with a bit-serial divider. Uses bbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bbc_front (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire                         i_func,
    input  wire  [bbc_pkg::SECTOR_W-1:0] i_sector,
    input  wire                         i_write,
    input  wire  [bbc_pkg::SPB_W-1:0]    i_spb,
    input  wire  [bbc_pkg::SECTOR_W-1:0] i_vol,
    output logic                        o_push,
    output bbc_pkg::t_req               o_req,
    input  wire                         i_full
);
    import bbc_pkg::*;
    localparam int CNT_W = $clog2(SECTOR_W + 1);

    t_fstate             r_st, n_st;
    t_req                r_req, n_req;
    logic [SPB_W-1:0]    r_rem, n_rem;
    logic [SPB_W-1:0]    r_div, n_div;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [SPB_W:0]      w_trial;
    logic [SECTOR_W-1:0] w_fill;

    assign w_trial = {r_rem, r_req.sector[r_cnt[5:0] - 6'd1]} - {1'b0, r_div};
    // aligned start is the sector minus its offset within the buffer
    assign w_fill  = r_req.sector - SECTOR_W'(r_rem);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            F_IDLE: if (i_valid) n_st = (i_func || i_sector >= i_vol) ? F_PUSH : F_DIV;
            F_DIV:  if (r_cnt == CNT_W'(1)) n_st = F_PUSH;
            F_PUSH: if (!i_full) n_st = F_IDLE;
            default: n_st = F_IDLE;
        endcase
    end

    always_comb begin
        n_req = r_req;
        n_rem = r_rem;
        n_div = r_div;
        n_cnt = r_cnt;
        unique case (r_st)
            F_IDLE: begin
                n_req.kind   = i_func ? K_FLUSH : (i_sector >= i_vol ? K_RANGE : K_ACCESS);
                n_req.write  = i_write;
                n_req.sector = i_sector;
                n_req.fill   = '0;
                n_rem = '0;
                n_div = (i_spb == '0) ? SPB_W'(1) : i_spb;
                n_cnt = CNT_W'(SECTOR_W);
            end
            F_DIV: begin
                // one remainder step per cycle, most significant bit first
                if (!w_trial[SPB_W]) begin
                    n_rem = w_trial[SPB_W-1:0];
                end else begin
                    n_rem = {r_rem[SPB_W-2:0], r_req.sector[r_cnt[5:0] - 6'd1]};
                end
                n_cnt = r_cnt - CNT_W'(1);
            end
            F_PUSH: begin
                n_req.fill = r_req.kind == K_ACCESS ? w_fill : '0;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stall = (r_st != F_IDLE);
        o_push  = (r_st == F_PUSH) && !i_full;
        o_req   = r_req;
        o_req.fill = (r_req.kind == K_ACCESS) ? w_fill : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= F_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_req <= n_req;
        r_rem <= n_rem;
        r_div <= n_div;
        r_cnt <= n_cnt;
    end

    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == F_DIV) |-> (r_cnt != '0)) else $error("divider count underflow");
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full) else $error("push into full queue");
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == F_PUSH && i_full) |=> (r_st == F_PUSH)) else $error("lost request");
endmodule
`default_nettype wire

/* rtl/bbc_queue.sv */
// Two-entry request queue between front end and back end. Uses bbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bbc_queue (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  wire bbc_pkg::t_req i_req,
    output logic               o_full,
    input  wire                i_pop,
    output logic               o_empty,
    output bbc_pkg::t_req      o_req
);
    import bbc_pkg::*;
    t_req       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_req;
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue overflow");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue underflow");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count out of range");
endmodule
`default_nettype wire

/* rtl/bbc_back.sv */
// Back end: tag scan, LRU victim choice, flush walk and result register.
// Uses bbc_pkg; buffer state in flip-flops, scanned one buffer a cycle.
`timescale 1ns / 1ps
`default_nettype none
module bbc_back #(
    parameter int BUFFERS = bbc_pkg::BUFFERS_DEFAULT
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_empty,
    input  wire bbc_pkg::t_req           i_req,
    output logic                         o_pop,
    input  wire  [bbc_pkg::SPB_W-1:0]     i_spb,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [2:0]                   o_status,
    output logic [bbc_pkg::IDX_W-1:0]     o_buffer_index,
    output logic                         o_writeback_valid,
    output logic [bbc_pkg::SECTOR_W-1:0]  o_writeback_first_sector,
    output logic                         o_fill_valid,
    output logic [bbc_pkg::SECTOR_W-1:0]  o_fill_first_sector,
    output logic                         o_last
);
    import bbc_pkg::*;
    localparam int BI_W = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
    localparam int CW   = $clog2(BUFFERS + 1);

    t_bstate             r_st, n_st;
    logic [BUFFERS-1:0]  r_used, r_dirty;
    logic [SECTOR_W-1:0] r_first [BUFFERS];
    logic [STAMP_W-1:0]  r_stamp [BUFFERS];
    logic [STAMP_W-1:0]  r_age;
    logic [CW-1:0]       r_i;
    logic [BI_W-1:0]     w_i;
    logic                r_hit, r_free;
    logic [BI_W-1:0]     r_hidx, r_fidx, r_vidx;
    logic [STAMP_W-1:0]  r_vstamp;
    t_req                r_req;
    logic                r_ov;
    logic [2:0]          r_status;
    logic [IDX_W-1:0]    r_idx;
    logic                r_wbv, r_fv, r_last;
    logic [SECTOR_W-1:0] r_wbs, r_fs;
    logic [SPB_W-1:0]    w_n;
    logic [SECTOR_W:0]   w_end;
    logic                w_match, w_slot, w_emit;

    assign w_i   = r_i[BI_W-1:0];
    assign w_n   = (i_spb == '0) ? SPB_W'(1) : i_spb;
    assign w_end = {1'b0, r_first[w_i]} + (SECTOR_W+1)'(w_n);
    assign w_match = r_used[w_i] && r_req.sector >= r_first[w_i]
                     && {1'b0, r_req.sector} < w_end;
    assign w_slot  = (r_ov && i_stall);
    assign o_pop   = (r_st == B_IDLE) && !i_empty;
    // load a new result this cycle
    assign w_emit  = !w_slot && ((r_st == B_EMIT) || (r_st == B_DONE)
                     || (r_st == B_FLUSH && r_i != CW'(BUFFERS)
                         && r_used[w_i] && r_dirty[w_i]));

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            B_IDLE: if (!i_empty) begin
                unique case (i_req.kind)
                    K_FLUSH:  n_st = B_FLUSH;
                    K_RANGE:  n_st = B_DONE;
                    default:  n_st = B_SCAN;
                endcase
            end
            B_SCAN:  if (r_hit || r_i == CW'(BUFFERS - 1)) n_st = B_PICK;
            B_PICK:  n_st = B_EMIT;
            B_EMIT:  if (!w_slot) n_st = B_IDLE;
            B_FLUSH: if (!w_slot && r_i == CW'(BUFFERS)) n_st = B_DONE;
            B_DONE:  if (!w_slot) n_st = B_IDLE;
            default: n_st = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= B_IDLE;
            r_used  <= '0;
            r_dirty <= '0;
            r_age   <= '0;
            r_ov    <= 1'b0;
            for (int k = 0; k < BUFFERS; k++) r_stamp[k] <= '0;
        end else begin
            r_st <= n_st;
            if (w_emit) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            unique case (r_st)
                B_IDLE: if (!i_empty) begin
                    r_req <= i_req;
                    r_i   <= '0;
                    r_hit <= 1'b0;
                    r_free <= 1'b0;
                    r_vidx <= '0;
                    r_vstamp <= r_stamp[0];
                end
                B_SCAN: begin
                    if (w_match) begin
                        r_hit  <= 1'b1;
                        r_hidx <= w_i;
                    end
                    if (!r_used[w_i] && !r_free) begin
                        r_free <= 1'b1;
                        r_fidx <= w_i;
                    end
                    if (r_stamp[w_i] < r_vstamp) begin
                        r_vstamp <= r_stamp[w_i];
                        r_vidx   <= w_i;
                    end
                    if (!w_match) r_i <= r_i + CW'(1);
                end
                B_PICK: begin
                    // settle the chosen buffer and move the index there
                    r_hidx <= r_hit ? r_hidx : (r_free ? r_fidx : r_vidx);
                end
                B_EMIT: if (!w_slot) begin
                    r_idx <= IDX_W'(r_hidx);
                    r_last <= 1'b1;
                    r_stamp[r_hidx] <= r_age;
                    r_age <= r_age + STAMP_W'(1);
                    if (r_hit) begin
                        r_status <= ST_HIT;
                        r_wbv <= 1'b0; r_wbs <= '0; r_fv <= 1'b0; r_fs <= '0;
                        r_dirty[r_hidx] <= r_dirty[r_hidx] | r_req.write;
                    end else begin
                        r_status <= ST_MISS;
                        r_wbv <= !r_free && r_dirty[r_hidx];
                        r_wbs <= (!r_free && r_dirty[r_hidx]) ? r_first[r_hidx] : '0;
                        r_fv  <= 1'b1;
                        r_fs  <= r_req.fill;
                        r_used[r_hidx]  <= 1'b1;
                        r_first[r_hidx] <= r_req.fill;
                        r_dirty[r_hidx] <= r_req.write;
                    end
                end
                B_FLUSH: if (!w_slot && r_i != CW'(BUFFERS)) begin
                    r_i <= r_i + CW'(1);
                    if (r_used[w_i] && r_dirty[w_i]) begin
                        r_status <= ST_FLUSH_WB;
                        r_idx <= IDX_W'(w_i);
                        r_wbv <= 1'b1; r_wbs <= r_first[w_i];
                        r_fv <= 1'b0; r_fs <= '0; r_last <= 1'b0;
                        r_dirty[w_i] <= 1'b0;
                    end
                end
                B_DONE: if (!w_slot) begin
                    r_status <= (r_req.kind == K_FLUSH) ? ST_FLUSH_DN : ST_RANGE;
                    r_idx <= '0;
                    r_wbv <= 1'b0; r_wbs <= '0; r_fv <= 1'b0; r_fs <= '0;
                    r_last <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_valid = r_ov;
        o_status = r_status;
        o_buffer_index = r_idx;
        o_writeback_valid = r_wbv;
        o_writeback_first_sector = r_wbs;
        o_fill_valid = r_fv;
        o_fill_first_sector = r_fs;
        o_last = r_last;
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> (r_ov && $stable(r_status) && $stable(r_idx)))
        else $error("result changed under stall");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_st != B_IDLE)) else $error("pop without start");
    a_dirty_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dirty & ~r_used) == '0) else $error("dirty flag on unused buffer");
endmodule
`default_nettype wire

/* rtl/block_buffer_cache_lru.sv */
// Top level of the block buffer cache controller: config registers,
// front end, request queue and back end. Uses bbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
// The front end accepts an access request, runs the bit-serial division that
// finds the sector's offset within its buffer, and then pushes the request into
// the queue, waiting while the queue is full; it takes no new request until the
// push. The back end pops the request, scans up to BUFFERS tags one per cycle
// (stopping early on a hit), then picks and emits the result. Out-of-range and
// flush requests skip the division; a flush walks every buffer in the back end
// and waits while the output is stalled. The two-entry queue lets the front end
// divide the next request while the back end scans the current one.
module block_buffer_cache_lru #(
    parameter int BUFFERS = bbc_pkg::BUFFERS_DEFAULT
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire  [0:0]                  i_cfg_index,
    input  wire  [bbc_pkg::SECTOR_W-1:0] i_cfg_data,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire                         i_func,
    input  wire  [bbc_pkg::SECTOR_W-1:0] i_sector,
    input  wire                         i_write,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic [2:0]                  o_status,
    output logic [bbc_pkg::IDX_W-1:0]    o_buffer_index,
    output logic                        o_writeback_valid,
    output logic [bbc_pkg::SECTOR_W-1:0] o_writeback_first_sector,
    output logic                        o_fill_valid,
    output logic [bbc_pkg::SECTOR_W-1:0] o_fill_first_sector,
    output logic                        o_last
);
    import bbc_pkg::*;
    logic [SPB_W-1:0]    r_spb;
    logic [SECTOR_W-1:0] r_vol;
    logic                w_push, w_full, w_pop, w_empty;
    t_req                w_freq, w_qreq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spb <= SPB_W'(8);
            r_vol <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_SPB) r_spb <= i_cfg_data[SPB_W-1:0];
            else r_vol <= i_cfg_data;
        end
    end

    bbc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_func, .i_sector, .i_write,
        .i_spb(r_spb), .i_vol(r_vol), .o_push(w_push), .o_req(w_freq),
        .i_full(w_full)
    );

    bbc_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_req(w_freq), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_req(w_qreq)
    );

    bbc_back #(.BUFFERS(BUFFERS)) u_back (
        .i_clk, .i_rst_n, .i_empty(w_empty), .i_req(w_qreq), .o_pop(w_pop),
        .i_spb(r_spb), .o_valid, .i_stall, .o_status, .o_buffer_index,
        .o_writeback_valid, .o_writeback_first_sector, .o_fill_valid,
        .o_fill_first_sector, .o_last
    );
endmodule
`default_nettype wire
